### src/apv_pkg.sv
`default_nettype none
package apv_pkg;

  // Sequencer states of the voice
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ATK_DIV,
    ST_HAM_LEN_DIV,
    ST_SUS_DIV,
    ST_HARM_MUL,
    ST_DECAY_MUL,
    ST_NOISE_DIV,
    ST_NOISE_MUL,
    ST_GAIN_MUL,
    ST_ENV_DIV,
    ST_OUT_MUL,
    ST_FINISH
  } apv_state_e;

  // Input operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Serial multiplier operand widths
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 17;

  localparam logic [17:0] RATE_RESET   = 18'd48000;
  localparam logic [15:0] LFSR_SEED    = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS    = 16'hB400;
  localparam int unsigned HAMMER_GAIN  = 164;
  localparam int unsigned ATTACK_DIV   = 200;
  localparam int unsigned HAMMER_DIV   = 50;
  localparam int unsigned SUSTAIN_DIV  = 10;
  localparam int unsigned Q15_ONE      = 32768;

  localparam longint unsigned PI_Q30    = 64'd3373259426;
  localparam longint unsigned ONE_Q30   = 64'd1073741824;
  localparam longint unsigned MILLI_Q30 = 64'd1073742;

  // Unsigned quotient by shift and subtract, for table generation
  function automatic longint unsigned udiv64(longint unsigned a, longint unsigned b);
    longint unsigned q;
    longint unsigned r;
    q = 64'd0;
    r = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // exp(-z), z and result in Q30, for 0 <= z <= 0.75
  function automatic longint unsigned exp_neg_q30(longint unsigned z);
    longint acc;
    longint unsigned term;
    acc  = longint'(ONE_Q30);
    term = ONE_Q30;
    for (int n = 1; n <= 14; n++) begin
      term = udiv64((term * z) >> 30, 64'(n));
      if (n[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // sin(x), x and result in Q30, for 0 <= x <= pi/2
  function automatic longint unsigned sin_q30(longint unsigned x);
    longint acc;
    longint unsigned term;
    acc  = longint'(x);
    term = x;
    for (int n = 1; n <= 7; n++) begin
      term = udiv64((((term * x) >> 30) * x) >> 30, 64'((2 * n) * (2 * n + 1)));
      if (n[0]) acc = acc - longint'(term);
      else acc = acc + longint'(term);
    end
    return (acc < 0) ? 64'd0 : longint'(acc);
  endfunction

  // Quarter-wave sine entry rp of a table of 2**depth_log2 entries, Q1.15
  function automatic int unsigned sine_entry(int unsigned rp, int unsigned depth_log2);
    longint unsigned v;
    v = (sin_q30((PI_Q30 * (64'd4 * rp)) >> (depth_log2 + 1)) + 64'd16384) >> 15;
    if (v > 64'd32767) v = 64'd32767;
    return int'(v);
  endfunction

  // Release curve exp(-3x) entry j of a table of 2**depth_log2 entries, Q15
  function automatic int unsigned release_entry(int unsigned j, int unsigned depth_log2);
    longint unsigned z;
    longint unsigned e;
    z = ((64'd3 * j) << 30) >> (depth_log2 + 2);
    e = exp_neg_q30(z);
    e = (e * e) >> 30;
    e = (e * e) >> 30;
    return int'((e + 64'd16384) >> 15);
  endfunction

  // Per-sample decay factor of harmonic h (from 1), Q16
  function automatic int unsigned decay_entry(int unsigned h);
    longint unsigned e;
    e = exp_neg_q30(MILLI_Q30 * h);
    return int'((e + 64'd8192) >> 14);
  endfunction

endpackage
`default_nettype wire

### src/additive_piano_voice_core.sv
`default_nettype none
// Each item runs through a sequencer that shares a bit-serial multiplier
// (17 steps) and divider (LENGTH_BITS+15 steps). A tick with no note goes
// straight to the output; with a note it works through the harmonics, then
// the hammer noise while in the hammer, the attack or release envelope, and the output gain.
// A start runs three divisions. One item at a time; results sit in an output register.
// Reset: no note, sample rate 48000, noise LFSR at its seed.
module additive_piano_voice_core #(
  parameter int unsigned HARMONICS           = 4,
  parameter int unsigned SINE_TABLE_DEPTH    = 1024,
  parameter int unsigned RELEASE_TABLE_DEPTH = 256,
  parameter int unsigned LENGTH_BITS         = 20
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_wr_en_i,
  input  wire logic [17:0]        cfg_wr_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic               op_i,
  input  wire logic [23:0]        phase_step_i,
  input  wire logic [19:0]        note_length_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [15:0]      sample_o,
  output logic                    last_o,
  output logic                    active_o
);

  localparam int unsigned LB   = LENGTH_BITS;
  localparam int unsigned DW   = LB + 15;
  localparam int unsigned HW   = (HARMONICS > 1) ? $clog2(HARMONICS) : 1;
  localparam int unsigned RB   = $clog2(RELEASE_TABLE_DEPTH);
  localparam int unsigned AW   = apv_pkg::MUL_A_W;
  localparam int unsigned BW   = apv_pkg::MUL_B_W;
  localparam int unsigned PW   = AW + BW;
  localparam int unsigned SUMW = AW + 1;

  apv_pkg::apv_state_e state_q, state_d;

  logic [17:0]          rate_q, rate_d;
  logic [LB-1:0]        idx_q, idx_d;
  logic [LB-1:0]        len_q, len_d;
  logic [23:0]          pacc_q, pacc_d;
  logic [23:0]          pinc_q, pinc_d;
  logic [15:0]          amp_q [HARMONICS];
  logic [15:0]          amp_d [HARMONICS];
  logic [LB-1:0]        atk_q, atk_d;
  logic [LB-1:0]        ham_q, ham_d;
  logic [LB-1:0]        sus_q, sus_d;
  logic [15:0]          lfsr_q, lfsr_d;
  logic                 snd_q, snd_d;
  logic [HW-1:0]        hcnt_q, hcnt_d;
  logic [23:0]          hph_q, hph_d;
  logic signed [SUMW-1:0] sum_q, sum_d;
  logic [15:0]          nmag_q, nmag_d;
  logic                 nneg_q, nneg_d;
  logic [15:0]          henv_q, henv_d;
  logic [15:0]          env_q, env_d;
  logic                 run_q, run_d;
  logic signed [15:0]   res_sample_q, res_sample_d;
  logic                 res_last_q, res_last_d;
  logic                 res_active_q, res_active_d;
  logic                 out_valid_q, out_valid_d;
  logic signed [15:0]   out_sample_q, out_sample_d;
  logic                 out_last_q, out_last_d;
  logic                 out_active_q, out_active_d;

  logic [15:0] decay_tab [HARMONICS];
  logic [15:0] amp_init [HARMONICS];
  logic [15:0] rel_tab [RELEASE_TABLE_DEPTH];

  for (genvar h = 0; h < HARMONICS; h++) begin : g_harm
    localparam int unsigned AMP0  = apv_pkg::Q15_ONE / (h + 1);
    localparam int unsigned DECAY = apv_pkg::decay_entry(h + 1);
    assign decay_tab[h] = 16'(DECAY);
    assign amp_init[h]  = 16'(AMP0);
  end

  for (genvar j = 0; j < RELEASE_TABLE_DEPTH; j++) begin : g_rel
    localparam int unsigned REL = apv_pkg::release_entry(j, RB);
    assign rel_tab[j] = 16'(REL);
  end

  // Shared serial units
  logic          mul_start, mul_busy, mul_done;
  logic [AW-1:0] mul_a;
  logic [BW-1:0] mul_b;
  logic [PW-1:0] mul_prod;
  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dvd;
  logic [LB-1:0] div_dvs;
  logic [DW-1:0] div_quot;
  logic          sine_neg;
  logic [14:0]   sine_mag;

  apv_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  apv_div #(.NW(DW), .DVW(LB)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  apv_sine_lut #(.DEPTH(SINE_TABLE_DEPTH)) u_sine (
    .phase_i (hph_q),
    .neg_o   (sine_neg),
    .mag_o   (sine_mag)
  );

  // Handshake and phase flags
  logic          in_acc, out_load, out_take;
  logic          mul_state, div_state;
  logic          last_harm, in_ham, in_atk, in_rel, env_flat;
  logic [LB-1:0] span;
  logic          sneg;
  logic [AW-1:0] smag;

  always_comb begin
    in_stall_o = state_q != apv_pkg::ST_IDLE;
    in_acc     = in_valid_i && !in_stall_o;
    out_take   = out_valid_q && !out_stall_i;
    out_load   = (state_q == apv_pkg::ST_FINISH) && (!out_valid_q || !out_stall_i);
    mul_state  = (state_q == apv_pkg::ST_HARM_MUL) || (state_q == apv_pkg::ST_DECAY_MUL) ||
                 (state_q == apv_pkg::ST_NOISE_MUL) || (state_q == apv_pkg::ST_GAIN_MUL) ||
                 (state_q == apv_pkg::ST_OUT_MUL);
    div_state  = (state_q == apv_pkg::ST_ATK_DIV) || (state_q == apv_pkg::ST_HAM_LEN_DIV) ||
                 (state_q == apv_pkg::ST_SUS_DIV) || (state_q == apv_pkg::ST_NOISE_DIV) ||
                 (state_q == apv_pkg::ST_ENV_DIV);
    mul_start  = mul_state && !run_q;
    div_start  = div_state && !run_q;
    last_harm  = hcnt_q == HW'(HARMONICS - 1);
    in_ham     = idx_q < ham_q;
    in_atk     = idx_q < atk_q;
    in_rel     = !in_atk && (idx_q > sus_q);
    env_flat   = !in_atk && !in_rel;
    span       = len_q - sus_q;
    sneg       = sum_q[SUMW-1];
    smag       = sneg ? AW'(-sum_q) : AW'(sum_q);
  end

  // Operand selection for the shared units
  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    div_dvd = '0;
    div_dvs = '0;
    case (state_q)
      apv_pkg::ST_HARM_MUL: begin
        mul_a = AW'(amp_q[hcnt_q]);
        mul_b = BW'(sine_mag);
      end
      apv_pkg::ST_DECAY_MUL: begin
        mul_a = AW'(amp_q[hcnt_q]);
        mul_b = BW'(decay_tab[hcnt_q]);
      end
      apv_pkg::ST_NOISE_MUL: begin
        mul_a = AW'(nmag_q);
        mul_b = BW'(henv_q);
      end
      apv_pkg::ST_GAIN_MUL: begin
        mul_a = mul_prod[AW-1:0];
        mul_b = BW'(apv_pkg::HAMMER_GAIN);
      end
      apv_pkg::ST_OUT_MUL: begin
        mul_a = smag;
        mul_b = env_flat ? BW'(apv_pkg::Q15_ONE) : BW'(env_q);
      end
      apv_pkg::ST_ATK_DIV: begin
        div_dvd = DW'(rate_q);
        div_dvs = LB'(apv_pkg::ATTACK_DIV);
      end
      apv_pkg::ST_HAM_LEN_DIV: begin
        div_dvd = DW'(rate_q);
        div_dvs = LB'(apv_pkg::HAMMER_DIV);
      end
      apv_pkg::ST_SUS_DIV: begin
        div_dvd = DW'({len_q, 3'b000}) - DW'(len_q);
        div_dvs = LB'(apv_pkg::SUSTAIN_DIV);
      end
      apv_pkg::ST_NOISE_DIV: begin
        div_dvd = {idx_q, 15'd0};
        div_dvs = ham_q;
      end
      apv_pkg::ST_ENV_DIV: begin
        div_dvd = in_atk ? {idx_q, 15'd0} : DW'({idx_q - sus_q, {RB{1'b0}}});
        div_dvs = in_atk ? atk_q : span;
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      apv_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (op_i == apv_pkg::OP_START) state_d = apv_pkg::ST_ATK_DIV;
          else if (snd_q) state_d = apv_pkg::ST_HARM_MUL;
          else state_d = apv_pkg::ST_FINISH;
        end
      end
      apv_pkg::ST_ATK_DIV:     if (div_done) state_d = apv_pkg::ST_HAM_LEN_DIV;
      apv_pkg::ST_HAM_LEN_DIV: if (div_done) state_d = apv_pkg::ST_SUS_DIV;
      apv_pkg::ST_SUS_DIV:     if (div_done) state_d = apv_pkg::ST_IDLE;
      apv_pkg::ST_HARM_MUL:    if (mul_done) state_d = apv_pkg::ST_DECAY_MUL;
      apv_pkg::ST_DECAY_MUL: begin
        if (mul_done) begin
          if (!last_harm) state_d = apv_pkg::ST_HARM_MUL;
          else if (in_ham) state_d = apv_pkg::ST_NOISE_DIV;
          else if (env_flat) state_d = apv_pkg::ST_OUT_MUL;
          else state_d = apv_pkg::ST_ENV_DIV;
        end
      end
      apv_pkg::ST_NOISE_DIV:   if (div_done) state_d = apv_pkg::ST_NOISE_MUL;
      apv_pkg::ST_NOISE_MUL:   if (mul_done) state_d = apv_pkg::ST_GAIN_MUL;
      apv_pkg::ST_GAIN_MUL: begin
        if (mul_done) state_d = env_flat ? apv_pkg::ST_OUT_MUL : apv_pkg::ST_ENV_DIV;
      end
      apv_pkg::ST_ENV_DIV:     if (div_done) state_d = apv_pkg::ST_OUT_MUL;
      apv_pkg::ST_OUT_MUL:     if (mul_done) state_d = apv_pkg::ST_FINISH;
      apv_pkg::ST_FINISH:      if (out_load) state_d = apv_pkg::ST_IDLE;
      default:                 state_d = apv_pkg::ST_IDLE;
    endcase
  end

  // Datapath updates
  logic [15:0]     lfsr_nx;
  logic [PW:0]     rnd;
  logic [PW-30:0]  rq;
  logic [PW-1:0]   gsh;
  logic [LB:0]     idx_inc;
  logic            is_last;
  logic [DW-1:0]   rel_idx;

  always_comb begin
    rate_d       = cfg_wr_en_i ? cfg_wr_data_i : rate_q;
    idx_d        = idx_q;
    len_d        = len_q;
    pacc_d       = pacc_q;
    pinc_d       = pinc_q;
    amp_d        = amp_q;
    atk_d        = atk_q;
    ham_d        = ham_q;
    sus_d        = sus_q;
    lfsr_d       = lfsr_q;
    snd_d        = snd_q;
    hcnt_d       = hcnt_q;
    hph_d        = hph_q;
    sum_d        = sum_q;
    nmag_d       = nmag_q;
    nneg_d       = nneg_q;
    henv_d       = henv_q;
    env_d        = env_q;
    res_sample_d = res_sample_q;
    res_last_d   = res_last_q;
    res_active_d = res_active_q;
    run_d        = run_q;

    lfsr_nx = {1'b0, lfsr_q[15:1]} ^ (lfsr_q[0] ? apv_pkg::LFSR_TAPS : 16'd0);
    rnd     = sneg ? ({1'b0, mul_prod} + (PW+1)'(32'h1FFF_FFFF))
                   : ({1'b0, mul_prod} + (PW+1)'(32'h2000_0000));
    rq      = rnd[PW:30];
    gsh     = nneg_q ? ((mul_prod + PW'(32767)) >> 15) : (mul_prod >> 15);
    idx_inc = {1'b0, idx_q} + 1'b1;
    is_last = idx_inc >= {1'b0, len_q};
    rel_idx = (div_quot >= DW'(RELEASE_TABLE_DEPTH)) ? DW'(RELEASE_TABLE_DEPTH - 1) : div_quot;
    if (span == '0) rel_idx = '0;

    // Track whether the current unit state has launched its operation
    if (mul_start || div_start) run_d = 1'b1;
    if (mul_done || div_done) run_d = 1'b0;

    case (state_q)
      apv_pkg::ST_IDLE: begin
        if (in_acc && (op_i == apv_pkg::OP_START)) begin
          pinc_d = phase_step_i;
          len_d  = LB'(note_length_i);
          idx_d  = '0;
          pacc_d = '0;
          amp_d  = amp_init;
          atk_d  = '0;
          ham_d  = '0;
          snd_d  = LB'(note_length_i) != '0;
        end else if (in_acc) begin
          hcnt_d       = '0;
          hph_d        = pacc_q;
          sum_d        = '0;
          res_sample_d = '0;
          res_last_d   = 1'b0;
          res_active_d = 1'b0;
        end
      end
      apv_pkg::ST_ATK_DIV: begin
        if (div_done) atk_d = (div_quot >= DW'(len_q)) ? len_q : LB'(div_quot);
      end
      apv_pkg::ST_HAM_LEN_DIV: begin
        if (div_done) ham_d = (div_quot >= DW'(len_q)) ? len_q : LB'(div_quot);
      end
      apv_pkg::ST_SUS_DIV: begin
        if (div_done) sus_d = LB'(div_quot);
      end
      apv_pkg::ST_HARM_MUL: begin
        if (mul_done) begin
          sum_d = sine_neg ? (sum_q - SUMW'(mul_prod)) : (sum_q + SUMW'(mul_prod));
        end
      end
      apv_pkg::ST_DECAY_MUL: begin
        if (mul_done) begin
          amp_d[hcnt_q] = mul_prod[31:16];
          hcnt_d        = hcnt_q + 1'b1;
          hph_d         = hph_q + pacc_q;
          // Step the noise source once per hammer sample
          if (last_harm && in_ham) begin
            lfsr_d = lfsr_nx;
            nneg_d = !lfsr_nx[15];
            nmag_d = lfsr_nx[15] ? {1'b0, lfsr_nx[14:0]} : (16'h8000 - lfsr_nx);
          end
        end
      end
      apv_pkg::ST_NOISE_DIV: begin
        if (div_done) henv_d = 16'(17'd32768 - 17'(div_quot[14:0]));
      end
      apv_pkg::ST_GAIN_MUL: begin
        if (mul_done) begin
          sum_d = nneg_q ? (sum_q - SUMW'(gsh)) : (sum_q + SUMW'(gsh));
        end
      end
      apv_pkg::ST_ENV_DIV: begin
        if (div_done) env_d = in_atk ? div_quot[15:0] : rel_tab[rel_idx[RB-1:0]];
      end
      apv_pkg::ST_OUT_MUL: begin
        if (mul_done) begin
          if (!sneg) res_sample_d = (rq > (PW-29)'(32767)) ? 16'sd32767 : 16'(rq);
          else res_sample_d = (rq > (PW-29)'(32768)) ? -16'sd32768 : 16'(-rq);
          res_last_d   = is_last;
          res_active_d = 1'b1;
          pacc_d       = pacc_q + pinc_q;
          idx_d        = idx_inc[LB-1:0];
          if (is_last) snd_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  // Output register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_last_d   = out_last_q;
    out_active_d = out_active_q;
    if (out_take) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d  = 1'b1;
      out_sample_d = res_sample_q;
      out_last_d   = res_last_q;
      out_active_d = res_active_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign sample_o    = out_sample_q;
  assign last_o      = out_last_q;
  assign active_o    = out_active_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= apv_pkg::ST_IDLE;
      rate_q      <= apv_pkg::RATE_RESET;
      idx_q       <= '0;
      len_q       <= '0;
      pacc_q      <= '0;
      pinc_q      <= '0;
      atk_q       <= '0;
      ham_q       <= '0;
      sus_q       <= '0;
      lfsr_q      <= apv_pkg::LFSR_SEED;
      snd_q       <= 1'b0;
      run_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int h = 0; h < HARMONICS; h++) amp_q[h] <= '0;
    end else begin
      state_q     <= state_d;
      rate_q      <= rate_d;
      idx_q       <= idx_d;
      len_q       <= len_d;
      pacc_q      <= pacc_d;
      pinc_q      <= pinc_d;
      atk_q       <= atk_d;
      ham_q       <= ham_d;
      sus_q       <= sus_d;
      lfsr_q      <= lfsr_d;
      snd_q       <= snd_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
      amp_q       <= amp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hcnt_q       <= hcnt_d;
    hph_q        <= hph_d;
    sum_q        <= sum_d;
    nmag_q       <= nmag_d;
    nneg_q       <= nneg_d;
    henv_q       <= henv_d;
    env_q        <= env_d;
    res_sample_q <= res_sample_d;
    res_last_q   <= res_last_d;
    res_active_q <= res_active_d;
    out_sample_q <= out_sample_d;
    out_last_q   <= out_last_d;
    out_active_q <= out_active_d;
  end

  a_snd_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    snd_q |-> (len_q != '0) && (idx_q < len_q))
    else $error("sounding voice with index past note length");

  a_atk_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (atk_q <= len_q) && (ham_q <= len_q))
    else $error("attack or hammer length exceeds note length");

  a_mul_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_start |-> !mul_busy)
    else $error("multiplier launched while busy");

  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider launched while busy");

  a_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> out_valid_q && (state_q == apv_pkg::ST_IDLE))
    else $error("result not registered after finish");

endmodule
`default_nettype wire

### src/apv_mul.sv
`default_nettype none
module apv_mul #(
  parameter int unsigned AW = 34,
  parameter int unsigned BW = 17
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [AW-1:0]      a_i,
  input  wire logic [BW-1:0]      b_i,
  output logic                    busy_o,
  output logic                    done_o,
  output logic [AW+BW-1:0]        prod_o
);

  localparam int unsigned CW = $clog2(BW + 1);

  logic [AW+BW-1:0] p_q, p_d;
  logic [AW-1:0]    a_q, a_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [AW:0]      part;

  // Shift-add: one multiplier bit per cycle, LSB first
  always_comb begin
    part   = {1'b0, p_q[AW+BW-1:BW]} + (p_q[0] ? {1'b0, a_q} : '0);
    p_d    = p_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      p_d    = {{AW{1'b0}}, b_i};
      a_d    = a_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      p_d   = {part, p_q[BW-1:1]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    a_q <= a_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign prod_o = p_q;

endmodule
`default_nettype wire

### src/apv_div.sv
`default_nettype none
module apv_div #(
  parameter int unsigned NW  = 35,
  parameter int unsigned DVW = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NW-1:0]   dividend_i,
  input  wire logic [DVW-1:0]  divisor_i,
  output logic                 busy_o,
  output logic                 done_o,
  output logic [NW-1:0]        quot_o
);

  localparam int unsigned CW = $clog2(NW + 1);

  logic [NW-1:0]  dq_q, dq_d;
  logic [DVW-1:0] rem_q, rem_d;
  logic [DVW-1:0] dvs_q, dvs_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           busy_q, busy_d;
  logic           done_q, done_d;
  logic [DVW:0]   rem_sh;
  logic [DVW:0]   rem_sub;
  logic           ge;

  // Restoring division: one quotient bit per cycle, MSB first
  always_comb begin
    rem_sh  = {rem_q, dq_q[NW-1]};
    ge      = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
    dq_d    = dq_q;
    rem_d   = rem_q;
    dvs_d   = dvs_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (start_i) begin
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      dq_d  = {dq_q[NW-2:0], ge};
      rem_d = ge ? rem_sub[DVW-1:0] : rem_sh[DVW-1:0];
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(NW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = dq_q;

endmodule
`default_nettype wire

### src/apv_sine_lut.sv
`default_nettype none
module apv_sine_lut #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic [23:0] phase_i,
  output logic             neg_o,
  output logic [14:0]      mag_o
);

  localparam int unsigned SW = $clog2(DEPTH);
  localparam int unsigned QD = DEPTH / 4;
  localparam int unsigned QW = SW - 1;

  logic [14:0]   rom [QD+1];
  logic [SW-1:0] idx;
  logic [QW-1:0] r;
  logic [QW-1:0] ra;

  // Quarter-wave table, one extra entry for the peak
  for (genvar k = 0; k <= QD; k++) begin : g_rom
    localparam int unsigned V = apv_pkg::sine_entry(k, SW);
    assign rom[k] = 15'(V);
  end

  // Fold the phase into the first quadrant
  always_comb begin
    idx   = phase_i[23 -: SW];
    r     = {1'b0, idx[SW-3:0]};
    ra    = idx[SW-2] ? (QW'(QD) - r) : r;
    neg_o = idx[SW-1];
    mag_o = rom[ra];
  end

endmodule
`default_nettype wire

### tb/sv/tb_additive_piano_voice_core.sv
`timescale 1ns / 1ps

module tb_additive_piano_voice_core;

  localparam int unsigned NUM_HARM   = 4;
  localparam int unsigned SINE_DEPTH = 1024;
  localparam int unsigned REL_DEPTH  = 256;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN_CYCLES = 400;

  typedef struct {
    logic signed [15:0] sample;
    logic               last;
    logic               active;
  } voice_out_t;

  // Voice predictor and store of expected output samples
  class voice_scoreboard;
    int signed       sine_q15 [SINE_DEPTH];
    longint unsigned release_q15 [REL_DEPTH];
    longint unsigned decay_q16 [NUM_HARM];
    logic [17:0]     rate;
    logic [19:0]     index, length, attack, hammer, sustain;
    logic [23:0]     phase, step;
    longint unsigned amp [NUM_HARM];
    logic [15:0]     lfsr;
    bit              playing;
    voice_out_t      pending[$];
    int unsigned     errors;

    // exp(-z), Q30, by truncated series
    function longint unsigned exp_series(longint unsigned z);
      longint signed   acc;
      longint unsigned term;
      acc = 64'd1 << 30;
      term = 64'd1 << 30;
      for (int n = 1; n <= 14; n++) begin
        term = ((term * z) >> 30) / n;
        if (n % 2) acc -= term;
        else acc += term;
      end
      return (acc < 0) ? 0 : acc;
    endfunction

    // sin(x), Q30, by truncated series
    function longint unsigned sin_series(longint unsigned x);
      longint signed   acc;
      longint unsigned term;
      acc = x;
      term = x;
      for (int n = 1; n <= 7; n++) begin
        term = ((((term * x) >> 30) * x) >> 30) / ((2 * n) * (2 * n + 1));
        if (n % 2) acc -= term;
        else acc += term;
      end
      return (acc < 0) ? 0 : acc;
    endfunction

    function new();
      longint unsigned q, r, v, e;
      for (int k = 0; k < SINE_DEPTH; k++) begin
        q = (4 * k) / SINE_DEPTH;
        r = 4 * k - q * SINE_DEPTH;
        if (q % 2) r = SINE_DEPTH - r;
        v = (sin_series((64'd3373259426 * r) / (2 * SINE_DEPTH)) + (64'd1 << 14)) >> 15;
        if (v > 32767) v = 32767;
        sine_q15[k] = (q >= 2) ? -int'(v) : int'(v);
      end
      for (int j = 0; j < REL_DEPTH; j++) begin
        e = exp_series(((64'd3 * j) << 30) / (4 * REL_DEPTH));
        e = (e * e) >> 30;
        e = (e * e) >> 30;
        release_q15[j] = (e + (64'd1 << 14)) >> 15;
      end
      for (int h = 0; h < NUM_HARM; h++) begin
        e = exp_series((h + 1) * 64'd1073742);
        decay_q16[h] = (e + (64'd1 << 13)) >> 14;
      end
      rate = 18'd48000;
      index = 0; length = 0; attack = 0; hammer = 0; sustain = 0;
      phase = 0; step = 0; lfsr = 16'hACE1; playing = 0; errors = 0;
      foreach (amp[h]) amp[h] = 0;
    endfunction

    // Advance the voice by one accepted item
    function void note_item(logic op, logic [23:0] ps, logic [19:0] len);
      longint signed   sum, env, y, noise, henv;
      longint unsigned p, span, ri;
      int unsigned     a, m;
      voice_out_t      r;
      if (op == apv_pkg::OP_START) begin
        a = rate / 200;
        m = rate / 50;
        step = ps;
        length = len;
        attack = (a < len) ? 20'(a) : len;
        hammer = (m < len) ? 20'(m) : len;
        sustain = 20'((64'(len) * 7) / 10);
        index = 0;
        phase = 0;
        foreach (amp[h]) amp[h] = 32768 / (h + 1);
        playing = (len != 0);
        return;
      end
      if (!playing) begin
        r.sample = 0; r.last = 0; r.active = 0;
        pending.push_back(r);
        return;
      end
      sum = 0;
      for (int h = 0; h < NUM_HARM; h++) begin
        p = ((h + 1) * 64'(phase)) & 64'hFFFFFF;
        sum += longint'(amp[h]) * sine_q15[(p * SINE_DEPTH) >> 24];
        amp[h] = (amp[h] * decay_q16[h]) >> 16;
      end
      // hammer noise burst
      if (index < hammer) begin
        lfsr = lfsr[0] ? ((lfsr >> 1) ^ 16'hB400) : (lfsr >> 1);
        noise = longint'(lfsr) - 32768;
        henv = 32768 - longint'((64'(index) * 32768) / hammer);
        sum += (noise * henv * 164) >>> 15;
      end
      if (index < attack) begin
        env = (64'(index) * 32768) / attack;
      end else if (index > sustain) begin
        span = 64'(length) - sustain;
        ri = span ? (64'(index - sustain) * REL_DEPTH) / span : 0;
        if (ri >= REL_DEPTH) ri = REL_DEPTH - 1;
        env = release_q15[ri];
      end else begin
        env = 32768;
      end
      y = (sum * env + (64'sd1 <<< 29)) >>> 30;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
      r.sample = y[15:0];
      r.last = (64'(index) + 1 >= length);
      r.active = 1;
      pending.push_back(r);
      phase = phase + step;
      if (64'(index) + 1 >= length) playing = 0;
      index = index + 1;
    endfunction

    // Compare one output transfer with the oldest expected sample
    function void check_sample(logic signed [15:0] s, logic l, logic a);
      voice_out_t x;
      if (pending.size() == 0) begin
        $display("%0t: unexpected output sample=%0d last=%0b active=%0b", $realtime, s, l, a);
        errors++;
        return;
      end
      x = pending.pop_front();
      if (s !== x.sample) begin
        $display("%0t: sample expected %0d actual %0d", $realtime, x.sample, s);
        errors++;
      end
      if (l !== x.last) begin
        $display("%0t: last expected %0b actual %0b", $realtime, x.last, l);
        errors++;
      end
      if (a !== x.active) begin
        $display("%0t: active expected %0b actual %0b", $realtime, x.active, a);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i = 0;
  logic               rst_ni = 0;
  logic               cfg_wr_en_i = 0;
  logic [17:0]        cfg_wr_data_i = 0;
  logic               in_valid_i = 0;
  logic               in_stall_o;
  logic               op_i = 0;
  logic [23:0]        phase_step_i = 0;
  logic [19:0]        note_length_i = 0;
  logic               out_valid_o;
  logic               out_stall_i = 0;
  logic signed [15:0] sample_o;
  logic               last_o;
  logic               active_o;

  voice_scoreboard sb = new();
  int unsigned burst_left = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned quiet_cycles = 0;

  additive_piano_voice_core DUT (
    .clk_i, .rst_ni, .cfg_wr_en_i, .cfg_wr_data_i,
    .in_valid_i, .in_stall_o, .op_i, .phase_step_i, .note_length_i,
    .out_valid_o, .out_stall_i, .sample_o, .last_o, .active_o
  );

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  // Check every output transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_sample(sample_o, last_o, active_o);
  end

  // Stall the output on a pattern that changes mode now and then
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(8, 60);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall_i <= 0;
      1: out_stall_i <= 1'($urandom_range(0, 1));
      2: out_stall_i <= ($urandom_range(0, 7) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_wr_en_i)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("additive_piano_voice_core regression: fail");
      $finish;
    end
  end

  // Drive one item, in bursts with random gaps
  task automatic put_item(logic op, logic [23:0] ps, logic [19:0] len);
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i <= 0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst_left--;
    in_valid_i <= 1;
    op_i <= op;
    phase_step_i <= ps;
    note_length_i <= len;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(op, ps, len);
  endtask

  // Hold off until every expected sample has come and the block is quiet
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_rate(logic [17:0] value);
    drain();
    cfg_wr_en_i <= 1;
    cfg_wr_data_i <= value;
    sb.rate = value;
    @(negedge clk_i);
    cfg_wr_en_i <= 0;
  endtask

  task automatic play_note(logic [23:0] ps, logic [19:0] len, int unsigned ticks);
    put_item(apv_pkg::OP_START, ps, len);
    repeat (ticks) put_item(apv_pkg::OP_TICK, 24'($urandom), 20'($urandom));
  endtask

  // Mostly whole notes with random content, some cut short, some noise
  task automatic random_phase(int unsigned count);
    int unsigned sent;
    logic [23:0] ps;
    logic [19:0] len;
    int unsigned ticks;
    sent = 0;
    while (sent < count) begin
      case ($urandom_range(0, 9))
        0: begin
          put_item(1'($urandom_range(0, 1)), 24'($urandom), 20'($urandom));
          sent++;
        end
        default: begin
          ps = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? 24'hFFFFFF : 24'h0)
                                           : 24'($urandom);
          len = ($urandom_range(0, 9) == 0) ? 20'($urandom_range(41, 200))
                                            : 20'($urandom_range(1, 40));
          ticks = ($urandom_range(0, 9) == 0) ? $urandom_range(0, len) : len + $urandom_range(0, 2);
          play_note(ps, len, ticks);
          sent += ticks + 1;
        end
      endcase
    end
  endtask

  initial begin
    logic [17:0] rates [7] = '{18'd8000, 18'd1000, 18'd192000, 18'd0,
                               18'd199, 18'h3FFFF, 18'd48000};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1;

    // Directed: idle tick, empty note, extremes, replacement during a note
    put_item(apv_pkg::OP_TICK, 24'hFFFFFF, 20'hFFFFF);
    play_note(24'h0, 20'h0, 2);
    play_note(24'hFFFFFF, 20'd3, 4);
    play_note(24'd1, 20'd1, 2);
    play_note(24'h400000, 20'hFFFFF, 5);
    play_note(24'h123456, 20'd5, 6);

    foreach (rates[k]) begin
      write_rate(rates[k]);
      random_phase(38);
    end

    drain();
    if (sb.errors == 0)
      $display("additive_piano_voice_core regression: pass");
    else
      $display("additive_piano_voice_core regression: fail");
    $finish;
  end

endmodule

### additive_piano_voice_core.f
src/apv_pkg.sv
src/apv_mul.sv
src/apv_div.sv
src/apv_sine_lut.sv
src/additive_piano_voice_core.sv
tb/sv/tb_additive_piano_voice_core.sv
